// File: rtl/assert_macros.svh
// Assertion macros used by the pifmt_checker module.
// Expects no other header; each macro samples on the clock argument given.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Signal keeps its value in the cycle after the condition.
`define ASSERT_STABLE(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("signal changed while held");

`endif

// File: rtl/pifmt_pkg.sv
// Package for the printf integer field formatter: codes, constants, structs.
// No dependencies.
package pifmt_pkg;

    localparam int MAX_WIDTH_DEF = 32;

    localparam int NUM_SLOTS = 22;
    localparam int DIG_W     = 4 * NUM_SLOTS;
    localparam int NDW       = 5;

    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_HEXL = 3'd3;
    localparam logic [2:0] MODE_HEXU = 3'd4;
    localparam logic [2:0] MODE_PTR  = 3'd5;

    localparam logic [2:0] SC_CHAR  = 3'd0;
    localparam logic [2:0] SC_SHORT = 3'd1;
    localparam logic [2:0] SC_INT   = 3'd2;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam logic [1:0] RDX_DEC = 2'd0;
    localparam logic [1:0] RDX_OCT = 2'd1;
    localparam logic [1:0] RDX_HEX = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef struct packed {
        logic       sign_en;
        logic [7:0] sign_char;
        logic [1:0] plen;
        logic [7:0] pre1_char;
        logic       upper;
        logic       left;
        logic       zero;
        logic [5:0] width;
    } fmt_t;

    typedef struct packed {
        logic           ready;
        logic [NDW-1:0] nd;
        logic [3:0]     top;
    } dig_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < 4'd10)
            return CH_ZERO + {4'b0, d};
        else
            return base + {4'b0, d} - 8'd10;
    endfunction

endpackage

// File: rtl/pifmt_ifs.sv
// Channel interfaces of the formatter: conversion request in, characters out.
// No dependencies.
interface pifmt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_value;
    logic [2:0]  size_code;
    logic [2:0]  mode;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        zero_pad;
    logic        alt_form;
    logic [5:0]  field_width;

    modport source (output valid, raw_value, size_code, mode, left_justify, force_plus,
                    space_sign, zero_pad, alt_form, field_width, input ready);
    modport sink (input valid, raw_value, size_code, mode, left_justify, force_plus,
                  space_sign, zero_pad, alt_form, field_width, output ready);
endinterface

interface pifmt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, out_char, last_char, input ready);
    modport sink (input valid, out_char, last_char, output ready);
endinterface

// File: rtl/pifmt_digit_gen.sv
// Digit generator: bit-serial double dabble for decimal, direct load for
// octal/hex, then leading-zero strip; digits pop out MSB first. Uses pifmt_pkg.
module pifmt_digit_gen (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           mag,
    input  logic [1:0]            sz,
    input  logic [1:0]            radix,
    input  logic                  pop,
    output pifmt_pkg::dig_stat_t  stat
);
    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_DAB  = 2'd1;
    localparam logic [1:0] G_NORM = 2'd2;
    localparam logic [1:0] G_RDY  = 2'd3;

    logic [1:0]                      st_reg, st_next;
    logic [6:0]                      it_reg, it_next;
    logic [63:0]                     bin_reg, bin_next;
    logic [pifmt_pkg::DIG_W-1:0]     dig_reg, dig_next;
    logic [pifmt_pkg::NDW-1:0]       nd_reg, nd_next;

    logic [pifmt_pkg::DIG_W-1:0]     dab_adj;
    logic [pifmt_pkg::DIG_W-1:0]     oct_load;
    logic [pifmt_pkg::DIG_W-1:0]     hex_load;
    logic [65:0]                     mag_ext;
    logic [63:0]                     bin_align;
    logic [6:0]                      bin_cnt;

    always_comb
    begin
        mag_ext = {2'b00, mag};
        for (int i = 0; i < pifmt_pkg::NUM_SLOTS; i++)
        begin
            oct_load[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
            dab_adj[4*i +: 4]  = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                              : dig_reg[4*i +: 4];
        end
        hex_load = {{(pifmt_pkg::DIG_W-64){1'b0}}, mag};
    end

    always_comb
    begin
        case (sz)
            pifmt_pkg::SZ_8:
            begin
                bin_align = {mag[7:0], 56'b0};
                bin_cnt   = 7'd8;
            end
            pifmt_pkg::SZ_16:
            begin
                bin_align = {mag[15:0], 48'b0};
                bin_cnt   = 7'd16;
            end
            pifmt_pkg::SZ_32:
            begin
                bin_align = {mag[31:0], 32'b0};
                bin_cnt   = 7'd32;
            end
            default:
            begin
                bin_align = mag;
                bin_cnt   = 7'd64;
            end
        endcase
    end

    always_comb
    begin
        st_next  = st_reg;
        it_next  = it_reg;
        bin_next = bin_reg;
        dig_next = dig_reg;
        nd_next  = nd_reg;
        if (start)
        begin
            nd_next = pifmt_pkg::NDW'(pifmt_pkg::NUM_SLOTS);
            if (radix == pifmt_pkg::RDX_DEC)
            begin
                st_next  = G_DAB;
                bin_next = bin_align;
                it_next  = bin_cnt;
                dig_next = '0;
            end
            else
            begin
                st_next  = G_NORM;
                dig_next = (radix == pifmt_pkg::RDX_HEX) ? hex_load : oct_load;
            end
        end
        else
        begin
            case (st_reg)
                G_DAB:
                begin
                    dig_next = {dab_adj[pifmt_pkg::DIG_W-2:0], bin_reg[63]};
                    bin_next = {bin_reg[62:0], 1'b0};
                    it_next  = it_reg - 7'd1;
                    if (it_reg == 7'd1)
                        st_next = G_NORM;
                end
                G_NORM:
                begin
                    if (dig_reg[pifmt_pkg::DIG_W-1 -: 4] == 4'd0 && nd_reg != 1)
                    begin
                        dig_next = {dig_reg[pifmt_pkg::DIG_W-5:0], 4'b0};
                        nd_next  = nd_reg - 1'b1;
                    end
                    else
                        st_next = G_RDY;
                end
                G_RDY:
                begin
                    if (pop)
                        dig_next = {dig_reg[pifmt_pkg::DIG_W-5:0], 4'b0};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= G_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        it_reg  <= it_next;
        bin_reg <= bin_next;
        dig_reg <= dig_next;
        nd_reg  <= nd_next;
    end

    assign stat.ready = (st_reg == G_RDY);
    assign stat.nd    = nd_reg;
    assign stat.top   = dig_reg[pifmt_pkg::DIG_W-1 -: 4];

endmodule

// File: rtl/pifmt_emitter.sv
// Character sequencer: walks pad, sign, prefix, zero pad, digits, trailing pad, one
// character per cycle into the output register while the sink keeps up. Uses pifmt_pkg.
module pifmt_emitter #(
    parameter int MAX_WIDTH = pifmt_pkg::MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  pifmt_pkg::fmt_t       fmt,
    input  pifmt_pkg::dig_stat_t  dstat,
    output logic                  pop,
    output logic                  done,
    pifmt_out_if.source           out_ch
);
    localparam int PAD_W = $clog2(MAX_WIDTH + 1);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_LPAD = 3'd1;
    localparam logic [2:0] E_SIGN = 3'd2;
    localparam logic [2:0] E_PRE0 = 3'd3;
    localparam logic [2:0] E_PRE1 = 3'd4;
    localparam logic [2:0] E_ZPAD = 3'd5;
    localparam logic [2:0] E_DIG  = 3'd6;
    localparam logic [2:0] E_RPAD = 3'd7;

    logic [2:0]                 st_reg, st_next;
    logic [PAD_W-1:0]           pad_reg, pad_next;
    logic                       pad_nz_reg, pad_nz_next;
    logic [pifmt_pkg::NDW-1:0]  dcnt_reg, dcnt_next;
    logic                       ov_reg, ov_next;
    logic [7:0]                 oc_reg, oc_next;
    logic                       ol_reg, ol_next;

    logic [6:0]  body;
    logic [6:0]  wide;
    logic [6:0]  pad_calc;
    logic        pad_nz;
    logic [7:0]  has;
    logic [2:0]  nxt_ph;
    logic        found;
    logic        emit;
    logic        stay;
    logic        last;
    logic [7:0]  ch;

    always_comb
    begin
        body     = {5'b0, fmt.plen} + {2'b0, dstat.nd};
        wide     = {1'b0, fmt.width};
        pad_calc = (wide > body) ? wide - body : 7'd0;
        pad_nz   = (st_reg == E_IDLE) ? (pad_calc != 7'd0) : pad_nz_reg;

        has         = '0;
        has[E_LPAD] = pad_nz && !fmt.zero && !fmt.left;
        has[E_SIGN] = fmt.sign_en;
        has[E_PRE0] = (fmt.plen != 2'd0);
        has[E_PRE1] = (fmt.plen == 2'd2);
        has[E_ZPAD] = pad_nz && fmt.zero;
        has[E_DIG]  = 1'b1;
        has[E_RPAD] = pad_nz && fmt.left;

        found  = 1'b0;
        nxt_ph = E_IDLE;
        for (int k = 1; k < 8; k++)
        begin
            if (!found && 3'(k) > st_reg && has[k])
            begin
                nxt_ph = 3'(k);
                found  = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (st_reg)
            E_LPAD:  ch = pifmt_pkg::CH_SPACE;
            E_SIGN:  ch = fmt.sign_char;
            E_PRE0:  ch = pifmt_pkg::CH_ZERO;
            E_PRE1:  ch = fmt.pre1_char;
            E_ZPAD:  ch = pifmt_pkg::CH_ZERO;
            E_DIG:   ch = pifmt_pkg::digit_char(dstat.top, fmt.upper);
            E_RPAD:  ch = pifmt_pkg::CH_SPACE;
            default: ch = pifmt_pkg::CH_SPACE;
        endcase
    end

    always_comb
    begin
        emit = (st_reg != E_IDLE) && (!ov_reg || out_ch.ready);
        case (st_reg)
            E_LPAD, E_ZPAD, E_RPAD: stay = (pad_reg != PAD_W'(1));
            E_DIG:                  stay = (dcnt_reg != pifmt_pkg::NDW'(1));
            default:                stay = 1'b0;
        endcase
        last = emit && !stay && (nxt_ph == E_IDLE);
        pop  = emit && (st_reg == E_DIG);
        done = last;

        st_next     = st_reg;
        pad_next    = pad_reg;
        pad_nz_next = pad_nz_reg;
        dcnt_next   = dcnt_reg;
        if (start)
        begin
            st_next     = nxt_ph;
            pad_next    = pad_calc[PAD_W-1:0];
            pad_nz_next = pad_nz;
            dcnt_next   = dstat.nd;
        end
        else if (emit)
        begin
            if (stay)
            begin
                if (st_reg == E_DIG)
                    dcnt_next = dcnt_reg - 1'b1;
                else
                    pad_next = pad_reg - 1'b1;
            end
            else
                st_next = nxt_ph;
        end

        ov_next = ov_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        if (emit)
        begin
            ov_next = 1'b1;
            oc_next = ch;
            ol_next = last;
        end
        else if (out_ch.ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= E_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg    <= pad_next;
        pad_nz_reg <= pad_nz_next;
        dcnt_reg   <= dcnt_next;
        oc_reg     <= oc_next;
        ol_reg     <= ol_next;
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.out_char  = oc_reg;
    assign out_ch.last_char = ol_reg;

endmodule

// File: rtl/printf_integer_field_formatter.sv
// Formats one printf integer conversion into a stream of ASCII characters,
// one transaction per character, last_char set on the final one. One
// conversion is in flight at a time; in_ch.ready returns once the final
// character sits in the output register. Per conversion: an accept step,
// then for decimal kinds one double-dabble step per argument bit (8, 16,
// 32 or 64), then the leading-zero strip, a start step, and one character
// per cycle (1 to MAX_WIDTH+1 characters) while the sink keeps up.
// Octal and hex skip the double-dabble loop. Uses pifmt_pkg and pifmt_ifs.
module printf_integer_field_formatter #(
    parameter int MAX_WIDTH = pifmt_pkg::MAX_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pifmt_in_if.sink     in_ch,
    pifmt_out_if.source  out_ch
);
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_CONV = 2'd1;
    localparam logic [1:0] T_EMIT = 2'd2;

    logic [1:0]            t_reg, t_next;
    pifmt_pkg::fmt_t       fmt_reg, fmt_next;

    logic                  accept;
    logic [2:0]            md;
    logic [1:0]            sz;
    logic [63:0]           mask;
    logic [63:0]           masked;
    logic                  msb;
    logic                  neg;
    logic                  nz;
    logic [63:0]           mag;
    logic [1:0]            radix;
    logic                  is_hex;
    logic                  emit_start;
    logic                  emit_done;
    logic                  pop;
    pifmt_pkg::dig_stat_t  dstat;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (t_reg == T_IDLE);

    always_comb
    begin
        md = (in_ch.mode > pifmt_pkg::MODE_PTR) ? pifmt_pkg::MODE_UDEC : in_ch.mode;
        case (in_ch.size_code)
            pifmt_pkg::SC_CHAR:  sz = pifmt_pkg::SZ_8;
            pifmt_pkg::SC_SHORT: sz = pifmt_pkg::SZ_16;
            pifmt_pkg::SC_INT:   sz = pifmt_pkg::SZ_32;
            default:             sz = pifmt_pkg::SZ_64;
        endcase
        if (md == pifmt_pkg::MODE_PTR)
            sz = pifmt_pkg::SZ_64;

        case (sz)
            pifmt_pkg::SZ_8:  mask = 64'h0000_0000_0000_00ff;
            pifmt_pkg::SZ_16: mask = 64'h0000_0000_0000_ffff;
            pifmt_pkg::SZ_32: mask = 64'h0000_0000_ffff_ffff;
            default:          mask = 64'hffff_ffff_ffff_ffff;
        endcase
        masked = in_ch.raw_value & mask;
        case (sz)
            pifmt_pkg::SZ_8:  msb = masked[7];
            pifmt_pkg::SZ_16: msb = masked[15];
            pifmt_pkg::SZ_32: msb = masked[31];
            default:          msb = masked[63];
        endcase
        neg = (md == pifmt_pkg::MODE_SDEC) && msb;
        nz  = |masked;
        mag = neg ? ((64'd0 - masked) & mask) : masked;

        is_hex = (md == pifmt_pkg::MODE_HEXL) || (md == pifmt_pkg::MODE_HEXU)
              || (md == pifmt_pkg::MODE_PTR);
        if (md == pifmt_pkg::MODE_OCT)
            radix = pifmt_pkg::RDX_OCT;
        else if (is_hex)
            radix = pifmt_pkg::RDX_HEX;
        else
            radix = pifmt_pkg::RDX_DEC;
    end

    always_comb
    begin
        fmt_next = fmt_reg;
        if (accept)
        begin
            fmt_next.upper     = (md == pifmt_pkg::MODE_HEXU);
            fmt_next.pre1_char = (md == pifmt_pkg::MODE_HEXU) ? pifmt_pkg::CH_X_UP
                                                              : pifmt_pkg::CH_X_LO;
            if (md == pifmt_pkg::MODE_PTR || (in_ch.alt_form && nz && is_hex))
                fmt_next.plen = 2'd2;
            else if (in_ch.alt_form && nz && md == pifmt_pkg::MODE_OCT)
                fmt_next.plen = 2'd1;
            else
                fmt_next.plen = 2'd0;
            fmt_next.sign_en = neg || (md == pifmt_pkg::MODE_SDEC
                                       && (in_ch.force_plus || in_ch.space_sign));
            if (neg)
                fmt_next.sign_char = pifmt_pkg::CH_MINUS;
            else if (in_ch.force_plus)
                fmt_next.sign_char = pifmt_pkg::CH_PLUS;
            else
                fmt_next.sign_char = pifmt_pkg::CH_SPACE;
            fmt_next.left  = in_ch.left_justify;
            fmt_next.zero  = in_ch.zero_pad && !in_ch.left_justify;
            fmt_next.width = ({26'b0, in_ch.field_width} > MAX_WIDTH) ? 6'(MAX_WIDTH)
                                                                       : in_ch.field_width;
        end
    end

    assign emit_start = (t_reg == T_CONV) && dstat.ready;

    always_comb
    begin
        t_next = t_reg;
        case (t_reg)
            T_IDLE: if (accept) t_next = T_CONV;
            T_CONV: if (dstat.ready) t_next = T_EMIT;
            T_EMIT: if (emit_done) t_next = T_IDLE;
            default: t_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= T_IDLE;
        else
            t_reg <= t_next;
    end

    always_ff @(posedge clk)
    begin
        fmt_reg <= fmt_next;
    end

    pifmt_digit_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .mag   (mag),
        .sz    (sz),
        .radix (radix),
        .pop   (pop),
        .stat  (dstat)
    );

    pifmt_emitter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (emit_start),
        .fmt    (fmt_reg),
        .dstat  (dstat),
        .pop    (pop),
        .done   (emit_done),
        .out_ch (out_ch)
    );

endmodule

// File: rtl/pifmt_checker.sv
// Port-level checker for the formatter, attached by bind.
// Depends on assert_macros.svh and the top level's channel interfaces.
`include "assert_macros.svh"

module pifmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);
    // one conversion at a time
    `ASSERT_PROP(in_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    `ASSERT_PROP(out_char_range, clk, rst_n, out_valid |-> (out_char >= 8'h20 && out_char <= 8'h7a))
    `ASSERT_PROP(out_valid_held, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `ASSERT_STABLE(out_payload_held, clk, rst_n, out_valid && !out_ready, {out_char, out_last})

endmodule

bind printf_integer_field_formatter pifmt_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.last_char)
);

// File: dv/printf_integer_field_formatter_tb.sv
// Self-checking testbench for printf_integer_field_formatter: directed table, then random
// conversions, each field predicted in SV and compared character by character.
// Depends on pifmt_pkg, pifmt_ifs and the formatter RTL.
module printf_integer_field_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_WIDTH    = pifmt_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 135;
    localparam int CALM_ITEMS   = 30;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 150;

    localparam logic [2:0] SC_LONG   = 3'd3;
    localparam logic [2:0] SC_LLONG  = 3'd4;
    localparam logic [2:0] SC_RSVD7  = 3'd7;
    localparam logic [2:0] MODE_RSV6 = 3'd6;
    localparam logic [2:0] MODE_RSV7 = 3'd7;

    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_PLUS  = 5'b01000;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ZERO  = 5'b00010;
    localparam logic [4:0] F_ALT   = 5'b00001;

    typedef struct {
        logic [63:0] raw_value;
        logic [2:0]  size_code;
        logic [2:0]  mode;
        logic        left_justify;
        logic        force_plus;
        logic        space_sign;
        logic        zero_pad;
        logic        alt_form;
        logic [5:0]  field_width;
    } conv_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } fchar_t;

    typedef struct {
        conv_t conv;
        string want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;
    logic hold_out_req = 1'b0;
    int   error_count = 0;

    fchar_t    pending_chars[$];
    stim_row_t stim_rows[$];

    pifmt_in_if  in_if();
    pifmt_out_if out_if();

    printf_integer_field_formatter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void enqueue_field(input logic [7:0] field[$]);
        fchar_t fc;
        foreach (field[i])
        begin
            fc.ch = field[i];
            fc.last = (i == field.size() - 1);
            pending_chars.push_back(fc);
        end
    endfunction

    function automatic void format_field(input conv_t c);
        logic [63:0] mag;
        logic [63:0] mask;
        logic [63:0] t;
        logic [2:0]  md;
        logic        neg;
        logic        zero;
        logic        is_hex;
        logic [7:0]  sign_ch;
        logic [7:0]  digs[$];
        logic [7:0]  field[$];
        int          bits;
        int          radix;
        int          plen;
        int          pad;
        int          w;
        string       glyphs;

        md = (c.mode > pifmt_pkg::MODE_PTR) ? pifmt_pkg::MODE_UDEC : c.mode;
        w = (c.field_width > MAX_WIDTH) ? MAX_WIDTH : int'(c.field_width);
        case (c.size_code)
            pifmt_pkg::SC_CHAR:  bits = 8;
            pifmt_pkg::SC_SHORT: bits = 16;
            pifmt_pkg::SC_INT:   bits = 32;
            default:             bits = 64;
        endcase
        if (md == pifmt_pkg::MODE_PTR)
            bits = 64;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        mag = c.raw_value & mask;
        neg = (md == pifmt_pkg::MODE_SDEC) && mag[bits-1];
        if (neg)
            mag = (~mag + 64'd1) & mask;

        radix = (md == pifmt_pkg::MODE_OCT) ? 8 : (md >= pifmt_pkg::MODE_HEXL) ? 16 : 10;
        glyphs = (md == pifmt_pkg::MODE_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
        t = mag;
        do
        begin
            digs.push_front(glyphs[int'(t % radix)]);
            t = t / radix;
        end
        while (t != 0);

        is_hex = (md == pifmt_pkg::MODE_HEXL) || (md == pifmt_pkg::MODE_HEXU);
        if (md == pifmt_pkg::MODE_PTR || (c.alt_form && mag != 0 && is_hex))
            plen = 2;
        else if (c.alt_form && mag != 0 && md == pifmt_pkg::MODE_OCT)
            plen = 1;
        else
            plen = 0;

        sign_ch = 8'h00;
        if (neg)
            sign_ch = pifmt_pkg::CH_MINUS;
        else if (md == pifmt_pkg::MODE_SDEC && c.force_plus)
            sign_ch = pifmt_pkg::CH_PLUS;
        else if (md == pifmt_pkg::MODE_SDEC && c.space_sign)
            sign_ch = pifmt_pkg::CH_SPACE;

        zero = c.zero_pad && !c.left_justify;
        pad = w - plen - digs.size();
        if (pad < 0)
            pad = 0;

        if (!zero && !c.left_justify)
            repeat (pad) field.push_back(pifmt_pkg::CH_SPACE);
        if (sign_ch != 8'h00)
            field.push_back(sign_ch);
        if (plen > 0)
            field.push_back(pifmt_pkg::CH_ZERO);
        if (plen == 2)
            field.push_back((md == pifmt_pkg::MODE_HEXU) ? pifmt_pkg::CH_X_UP
                                                         : pifmt_pkg::CH_X_LO);
        if (zero)
            repeat (pad) field.push_back(pifmt_pkg::CH_ZERO);
        foreach (digs[i])
            field.push_back(digs[i]);
        if (c.left_justify)
            repeat (pad) field.push_back(pifmt_pkg::CH_SPACE);
        enqueue_field(field);
    endfunction

    function automatic void add_row(input logic [63:0] raw, input logic [2:0] sc,
                                    input logic [2:0] md, input logic [4:0] flags,
                                    input logic [5:0] width, input string want);
        stim_row_t r;
        r.conv.raw_value    = raw;
        r.conv.size_code    = sc;
        r.conv.mode         = md;
        r.conv.left_justify = flags[4];
        r.conv.force_plus   = flags[3];
        r.conv.space_sign   = flags[2];
        r.conv.zero_pad     = flags[1];
        r.conv.alt_form     = flags[0];
        r.conv.field_width  = width;
        r.want              = want;
        stim_rows.push_back(r);
    endfunction

    function automatic conv_t random_conv();
        conv_t c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.raw_value = {$urandom, $urandom};
            4, 5:       c.raw_value = 64'($urandom_range(0, 1000));
            6:          c.raw_value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 2));
            7:          c.raw_value = '0;
            default:    c.raw_value = -64'($urandom_range(1, 1000));
        endcase
        c.size_code = 3'($urandom_range(0, 7));
        c.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        c.left_justify = 1'($urandom_range(0, 1));
        c.force_plus   = 1'($urandom_range(0, 1));
        c.space_sign   = 1'($urandom_range(0, 1));
        c.zero_pad     = 1'($urandom_range(0, 1));
        c.alt_form     = 1'($urandom_range(0, 1));
        c.field_width  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                     : 6'($urandom_range(0, 24));
        return c;
    endfunction

    task automatic offer_conv(input conv_t c, input string want);
        logic [7:0] field[$];
        @(negedge clk);
        in_if.valid        <= 1'b1;
        in_if.raw_value    <= c.raw_value;
        in_if.size_code    <= c.size_code;
        in_if.mode         <= c.mode;
        in_if.left_justify <= c.left_justify;
        in_if.force_plus   <= c.force_plus;
        in_if.space_sign   <= c.space_sign;
        in_if.zero_pad     <= c.zero_pad;
        in_if.alt_form     <= c.alt_form;
        in_if.field_width  <= c.field_width;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        if (want.len() == 0)
            format_field(c);
        else
        begin
            for (int i = 0; i < want.len(); i++)
                field.push_back(want[i]);
            enqueue_field(field);
        end
    endtask

    task automatic idle_input(input int n);
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_fields_drained();
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : out_pacer
        int n;
        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_out_req)
            begin
                hold_out_req = 1'b0;
                n = LONG_HOLD;
                out_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                out_if.ready <= 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 30);
                out_if.ready <= 1'b1;
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : char_check
        fchar_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("char %h with no field pending", out_if.out_char));
            else
            begin
                want = pending_chars.pop_front();
                if (out_if.out_char !== want.ch)
                    report_mismatch($sformatf("out_char %h, expected %h",
                                              out_if.out_char, want.ch));
                if (out_if.last_char !== want.last)
                    report_mismatch($sformatf("last_char %b, expected %b on char %h",
                                              out_if.last_char, want.last, want.ch));
            end
        end
    end

    initial
    begin : stimulus
        rst_n              <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.raw_value    <= '0;
        in_if.size_code    <= '0;
        in_if.mode         <= '0;
        in_if.left_justify <= 1'b0;
        in_if.force_plus   <= 1'b0;
        in_if.space_sign   <= 1'b0;
        in_if.zero_pad     <= 1'b0;
        in_if.alt_form     <= 1'b0;
        in_if.field_width  <= '0;

        add_row(64'h0, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_NONE, 6'd0, "0");
        add_row(64'h1234_5678_9ABC_DEFF, pifmt_pkg::SC_CHAR, pifmt_pkg::MODE_SDEC, F_NONE,
                6'd0, "-1");
        add_row(64'h80, pifmt_pkg::SC_CHAR, pifmt_pkg::MODE_SDEC, F_NONE, 6'd0, "-128");
        add_row(64'h80, pifmt_pkg::SC_CHAR, pifmt_pkg::MODE_UDEC, F_NONE, 6'd0, "128");
        add_row(64'hAAAA_AAAA_AAAA_FFFF, pifmt_pkg::SC_SHORT, pifmt_pkg::MODE_UDEC, F_NONE,
                6'd0, "65535");
        add_row('1, SC_LONG, pifmt_pkg::MODE_UDEC, F_NONE, 6'd0, "18446744073709551615");
        add_row(64'h8000_0000_0000_0000, SC_LLONG, pifmt_pkg::MODE_SDEC, F_NONE, 6'd0,
                "-9223372036854775808");
        add_row(64'h0, pifmt_pkg::SC_CHAR, pifmt_pkg::MODE_PTR, F_NONE, 6'd0, "0x0");
        add_row(64'hDEAD_BEEF, pifmt_pkg::SC_INT, pifmt_pkg::MODE_HEXU, F_ALT, 6'd0,
                "0XDEADBEEF");
        add_row(64'hDEAD_BEEF, pifmt_pkg::SC_INT, pifmt_pkg::MODE_HEXL, F_ALT, 6'd0,
                "0xdeadbeef");
        add_row(64'h8, pifmt_pkg::SC_INT, pifmt_pkg::MODE_OCT, F_ALT, 6'd0, "010");
        add_row(64'h0, pifmt_pkg::SC_INT, pifmt_pkg::MODE_HEXL, F_ALT, 6'd0, "0");
        add_row(64'h0, pifmt_pkg::SC_INT, pifmt_pkg::MODE_OCT, F_ALT, 6'd0, "0");
        add_row(64'h5, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_PLUS, 6'd0, "+5");
        add_row(64'h5, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_SPACE, 6'd0, " 5");
        add_row(64'h5, pifmt_pkg::SC_INT, pifmt_pkg::MODE_UDEC, F_PLUS | F_SPACE, 6'd0, "5");
        add_row(64'd42, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_NONE, 6'd6, "    42");
        add_row(64'd42, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_LEFT, 6'd6, "42    ");
        add_row(64'd42, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_ZERO | F_LEFT, 6'd6,
                "42    ");
        add_row(64'hFFFF_FFD6, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_ZERO, 6'd6,
                "-000042");
        add_row(64'h1, pifmt_pkg::SC_INT, pifmt_pkg::MODE_SDEC, F_PLUS | F_ZERO, 6'd63, "");
        add_row('1, SC_RSVD7, MODE_RSV6, F_ALT | F_SPACE, 6'd0, "");
        add_row(64'hFF, pifmt_pkg::SC_CHAR, MODE_RSV7, F_PLUS, 6'd32, "");
        add_row(64'h1234_5678_9ABC_DEF0, pifmt_pkg::SC_CHAR, pifmt_pkg::MODE_PTR,
                F_ZERO | F_PLUS, 6'd32, "");
        add_row('1, SC_LONG, pifmt_pkg::MODE_OCT, F_ALT | F_LEFT, 6'd40, "");

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 19));
            offer_conv(stim_rows[i].conv, stim_rows[i].want);
        end
        idle_input(1);
        wait_fields_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 10)
                hold_out_req = 1'b1;
            if (k == 80)
            begin
                idle_input(1);
                wait_fields_drained();
            end
            if (k == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 19));
            offer_conv(random_conv(), "");
        end
        idle_input(1);
        wait_fields_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
